@@ hw/rtl/tpsm_pkg.sv @@
// Shared types, codes and the report packing function of the three-phase sequence monitor.
`timescale 1ns / 1ps

package tpsm_pkg;

   localparam logic [1:0] MODE_CAPTURE_A = 2'd0;
   localparam logic [1:0] MODE_CAPTURE_B = 2'd1;
   localparam logic [1:0] MODE_CAPTURE_C = 2'd2;
   localparam logic [1:0] MODE_OVERFLOW  = 2'd3;

   localparam logic [3:0] CODE_NONE = 4'h0;
   localparam logic [3:0] CODE_A    = 4'hA;
   localparam logic [3:0] CODE_B    = 4'hB;
   localparam logic [3:0] CODE_C    = 4'hC;

   localparam logic [11:0] ORDER_ABC = 12'hABC;
   localparam logic [11:0] ORDER_BCA = 12'hBCA;
   localparam logic [11:0] ORDER_CAB = 12'hCAB;

   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_LAST   = 2'd2;

   localparam logic [15:0] WINDOW_LOW_RESET  = 16'd7168;
   localparam logic [15:0] WINDOW_HIGH_RESET = 16'd18432;

   localparam logic CSR_WINDOW_LOW  = 1'b0;
   localparam logic CSR_WINDOW_HIGH = 1'b1;

   typedef struct packed {
      logic [1:0]  slot_index;
      logic [11:0] order_record;
      logic [15:0] time_of_a;
      logic [15:0] time_of_b;
      logic [15:0] interval_ab;
      logic [15:0] interval_bc;
      logic [2:0]  loss_flags;
      logic        order_flag;
   } state_type;

   // Every loss flag starts set; all other sequence state starts at zero.
   localparam state_type STATE_RESET = {SLOT_FIRST, 12'h000, 16'h0000, 16'h0000,
                                        16'h0000, 16'h0000, 3'b111, 1'b0};

   typedef struct packed {
      logic [15:0] report_word;
      logic        loss_a;
      logic        loss_b;
      logic        loss_c;
      logic        order_ok;
      logic        evaluated;
   } result_type;

   function automatic logic [15:0] pack_report(input logic [2:0] loss, input logic order_ok);
      logic [15:0] w;
      w = 16'hFABC & 16'h00FF;
      if (!loss[0]) w = w | 16'h0AFF;
      w = w & 16'h0F0F;
      if (!loss[1]) w = w | 16'h0FBF;
      w = w & 16'h0FF0;
      if (!loss[2]) w = w | 16'h0FFC;
      if (order_ok) begin
         w = w | 16'hF000;
      end else begin
         w = w & 16'h0FFF;
         w = {w[15:8], w[3:0], w[7:4]};
      end
      return w;
   endfunction

endpackage

@@ hw/rtl/tpsm_eval.sv @@
// Next-state and result logic for one event of the three-phase sequence monitor.
`timescale 1ns / 1ps

module tpsm_eval (
   input  tpsm_pkg::state_type  cur,
   input  logic [1:0]           mode,
   input  logic [15:0]          capture_time,
   input  logic [15:0]          window_low,
   input  logic [15:0]          window_high,
   output tpsm_pkg::state_type  nxt,
   output tpsm_pkg::result_type res
);

   logic [3:0]  code;
   logic [11:0] record_in;
   logic        has_a;
   logic        has_b;
   logic        has_c;
   logic        ab_ok;
   logic        bc_ok;
   logic        rotation_ok;
   logic        last_slot;

   always_comb begin
      nxt = cur;
      code = tpsm_pkg::CODE_NONE;
      case (mode)
         tpsm_pkg::MODE_CAPTURE_A: begin
            code = tpsm_pkg::CODE_A;
            nxt.time_of_a = capture_time;
            nxt.loss_flags[0] = 1'b0;
         end
         tpsm_pkg::MODE_CAPTURE_B: begin
            code = tpsm_pkg::CODE_B;
            nxt.interval_ab = capture_time - cur.time_of_a;
            nxt.time_of_b = capture_time;
            nxt.loss_flags[1] = 1'b0;
         end
         tpsm_pkg::MODE_CAPTURE_C: begin
            code = tpsm_pkg::CODE_C;
            nxt.interval_bc = capture_time - cur.time_of_b;
            nxt.loss_flags[2] = 1'b0;
         end
         tpsm_pkg::MODE_OVERFLOW: begin
            code = tpsm_pkg::CODE_NONE;
         end
         default: begin
            code = tpsm_pkg::CODE_NONE;
         end
      endcase

      case (cur.slot_index)
         tpsm_pkg::SLOT_FIRST:  record_in = {cur.order_record[11:4], code};
         tpsm_pkg::SLOT_SECOND: record_in = {cur.order_record[11:8], code, cur.order_record[3:0]};
         default:               record_in = {code, cur.order_record[7:0]};
      endcase
      nxt.order_record = record_in;

      has_a = (record_in[3:0] == tpsm_pkg::CODE_A) || (record_in[7:4] == tpsm_pkg::CODE_A)
           || (record_in[11:8] == tpsm_pkg::CODE_A);
      has_b = (record_in[3:0] == tpsm_pkg::CODE_B) || (record_in[7:4] == tpsm_pkg::CODE_B)
           || (record_in[11:8] == tpsm_pkg::CODE_B);
      has_c = (record_in[3:0] == tpsm_pkg::CODE_C) || (record_in[7:4] == tpsm_pkg::CODE_C)
           || (record_in[11:8] == tpsm_pkg::CODE_C);
      ab_ok = (nxt.interval_ab > window_low) && (nxt.interval_ab < window_high);
      bc_ok = (nxt.interval_bc > window_low) && (nxt.interval_bc < window_high);
      rotation_ok = (record_in == tpsm_pkg::ORDER_ABC) || (record_in == tpsm_pkg::ORDER_BCA)
                 || (record_in == tpsm_pkg::ORDER_CAB);

      last_slot = (cur.slot_index == tpsm_pkg::SLOT_LAST);
      if (last_slot) begin
         nxt.loss_flags = {~has_c, ~has_b, ~has_a};
         nxt.order_flag = ab_ok && bc_ok && rotation_ok;
         nxt.slot_index = tpsm_pkg::SLOT_FIRST;
      end else begin
         nxt.slot_index = cur.slot_index + 2'd1;
      end

      res.report_word = tpsm_pkg::pack_report(nxt.loss_flags, nxt.order_flag);
      res.loss_a      = nxt.loss_flags[0];
      res.loss_b      = nxt.loss_flags[1];
      res.loss_c      = nxt.loss_flags[2];
      res.order_ok    = nxt.order_flag;
      res.evaluated   = last_slot;
   end

endmodule

@@ hw/rtl/three_phase_sequence_monitor.sv @@
// Top level of the three-phase sequence monitor: state, window registers and result buffering.
//
// The req_ channel takes one event per transaction: a capture on phase A, B or C with its
// timestamp, or a counter overflow. Each accepted transaction produces exactly one
// transaction on the rsp_ channel carrying the packed report word and the current loss,
// order and round-complete flags.
// The csr_ channel writes the interval window: index 0 is the lower bound, index 1 the
// upper bound. It is always ready and should be written only while the block is idle.
// The result is registered at the edge that accepts the event.
// Throughput is one event per cycle while req_stall is low; the state update is a single pass of logic.
// A two-entry output buffer decouples the channels, so an event is still accepted while
// one result waits on a stalled receiver; req_stall rises only when both entries are full.
// Synchronous reset clears all sequence state, sets every loss flag, restores the window
// to its default bounds and empties the output buffer.
`timescale 1ns / 1ps

module three_phase_sequence_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_capture_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_report_word,
   output logic        rsp_loss_a,
   output logic        rsp_loss_b,
   output logic        rsp_loss_c,
   output logic        rsp_order_ok,
   output logic        rsp_evaluated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   tpsm_pkg::state_type  state_ff;
   tpsm_pkg::state_type  state_in;
   tpsm_pkg::result_type result_in;
   tpsm_pkg::result_type out_ff;
   tpsm_pkg::result_type skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   logic [15:0]          window_low_ff;
   logic [15:0]          window_high_ff;
   logic                 accept;
   logic                 rsp_take;

   tpsm_eval u_eval (
      .cur          (state_ff),
      .mode         (req_mode),
      .capture_time (req_capture_time),
      .window_low   (window_low_ff),
      .window_high  (window_high_ff),
      .nxt          (state_in),
      .res          (result_in)
   );

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff  <= tpsm_pkg::WINDOW_LOW_RESET;
         window_high_ff <= tpsm_pkg::WINDOW_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == tpsm_pkg::CSR_WINDOW_LOW) begin
            window_low_ff <= csr_data;
         end else begin
            window_high_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpsm_pkg::STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_ff       <= result_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_report_word = out_ff.report_word;
   assign rsp_loss_a      = out_ff.loss_a;
   assign rsp_loss_b      = out_ff.loss_b;
   assign rsp_loss_c      = out_ff.loss_c;
   assign rsp_order_ok    = out_ff.order_ok;
   assign rsp_evaluated   = out_ff.evaluated;

endmodule

@@ tb/sv/three_phase_sequence_monitor_test.sv @@
// Self-checking testbench of the three-phase sequence monitor with its own behavioural predictor.
`timescale 1ns / 1ps

module three_phase_sequence_monitor_test;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = tpsm_pkg::MODE_OVERFLOW;
   logic [15:0] req_capture_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_report_word;
   logic        rsp_loss_a;
   logic        rsp_loss_b;
   logic        rsp_loss_c;
   logic        rsp_order_ok;
   logic        rsp_evaluated;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = tpsm_pkg::CSR_WINDOW_LOW;
   logic [15:0] csr_data = '0;

   // Predicted state of the monitor.
   logic [1:0]  slot_now = tpsm_pkg::SLOT_FIRST;
   logic [11:0] record_now = '0;
   logic [15:0] tm_a = '0;
   logic [15:0] tm_b = '0;
   logic [15:0] gap_ab = '0;
   logic [15:0] gap_bc = '0;
   logic [2:0]  loss_now = 3'b111;
   logic        in_order = 1'b0;
   logic [15:0] win_low = tpsm_pkg::WINDOW_LOW_RESET;
   logic [15:0] win_high = tpsm_pkg::WINDOW_HIGH_RESET;

   tpsm_pkg::result_type expected_reports [$];
   int failures = 0;
   int items_sent = 0;
   int results_seen = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   logic hold_request = 1'b0;
   logic hold_started = 1'b0;

   three_phase_sequence_monitor DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_capture_time(req_capture_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_report_word(rsp_report_word),
      .rsp_loss_a(rsp_loss_a),
      .rsp_loss_b(rsp_loss_b),
      .rsp_loss_c(rsp_loss_c),
      .rsp_order_ok(rsp_order_ok),
      .rsp_evaluated(rsp_evaluated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   task automatic note_failure(input string msg);
      $display("MISMATCH: %s", msg);
      failures++;
   endtask

   function automatic logic [15:0] status_word(input logic [2:0] loss, input logic ok);
      logic [15:0] base;
      if (!loss[2]) base = 16'h0FFC;
      else if (!loss[1]) base = 16'h0FB0;
      else if (!loss[0]) base = 16'h0A00;
      else base = 16'h0000;
      if (ok) return base | 16'hF000;
      return {base[15:8], base[3:0], base[7:4]};
   endfunction

   function automatic logic inside_window(input logic [15:0] gap);
      return gap > win_low && gap < win_high;
   endfunction

   task automatic predict_event(input logic [1:0] mode, input logic [15:0] stamp);
      logic [3:0] code;
      tpsm_pkg::result_type r;
      code = tpsm_pkg::CODE_NONE;
      case (mode)
         tpsm_pkg::MODE_CAPTURE_A: begin
            tm_a = stamp;
            loss_now[0] = 1'b0;
            code = tpsm_pkg::CODE_A;
         end
         tpsm_pkg::MODE_CAPTURE_B: begin
            gap_ab = stamp - tm_a;
            tm_b = stamp;
            loss_now[1] = 1'b0;
            code = tpsm_pkg::CODE_B;
         end
         tpsm_pkg::MODE_CAPTURE_C: begin
            gap_bc = stamp - tm_b;
            loss_now[2] = 1'b0;
            code = tpsm_pkg::CODE_C;
         end
         default: ;
      endcase
      record_now[slot_now * 4 +: 4] = code;
      r.evaluated = (slot_now == tpsm_pkg::SLOT_LAST);
      if (slot_now == tpsm_pkg::SLOT_LAST) begin
         loss_now = 3'b111;
         for (int s = 0; s < 3; s++) begin
            if (record_now[s * 4 +: 4] == tpsm_pkg::CODE_A) loss_now[0] = 1'b0;
            if (record_now[s * 4 +: 4] == tpsm_pkg::CODE_B) loss_now[1] = 1'b0;
            if (record_now[s * 4 +: 4] == tpsm_pkg::CODE_C) loss_now[2] = 1'b0;
         end
         in_order = inside_window(gap_ab) && inside_window(gap_bc)
            && (record_now == tpsm_pkg::ORDER_ABC || record_now == tpsm_pkg::ORDER_BCA
                || record_now == tpsm_pkg::ORDER_CAB);
         slot_now = tpsm_pkg::SLOT_FIRST;
      end else begin
         slot_now = slot_now + 2'd1;
      end
      r.report_word = status_word(loss_now, in_order);
      r.loss_a = loss_now[0];
      r.loss_b = loss_now[1];
      r.loss_c = loss_now[2];
      r.order_ok = in_order;
      expected_reports.push_back(r);
   endtask

   task automatic send_event(input logic [1:0] mode, input logic [15:0] stamp);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_capture_time <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_event(mode, stamp);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_window(input logic [15:0] lo, input logic [15:0] hi);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= tpsm_pkg::CSR_WINDOW_LOW;
      csr_data <= lo;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      win_low = lo;
      @(negedge clock);
      csr_index <= tpsm_pkg::CSR_WINDOW_HIGH;
      csr_data <= hi;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      win_high = hi;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic choose_idling(input int pattern);
      case (pattern % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
         default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
      endcase
   endtask

   function automatic logic [15:0] pick_interval();
      int lo;
      int hi;
      lo = win_low;
      hi = win_high;
      if (hi - lo >= 2 && $urandom_range(0, 99) < 80) return 16'($urandom_range(lo + 1, hi - 1));
      case ($urandom_range(0, 6))
         0: return 16'(lo);
         1: return 16'(lo + 1);
         2: return 16'(hi - 1);
         3: return 16'(hi);
         4: return 16'h0000;
         5: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [15:0] stamp_for(input logic [1:0] mode);
      case (mode)
         tpsm_pkg::MODE_CAPTURE_B: return tm_a + pick_interval();
         tpsm_pkg::MODE_CAPTURE_C: return tm_b + pick_interval();
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // A round in slot order C,B,A fills the record as ABC; the other two are its rotations.
   task automatic send_round(input int rotation, input logic broken);
      logic [1:0] events [3];
      case (rotation)
         0: events = '{tpsm_pkg::MODE_CAPTURE_C, tpsm_pkg::MODE_CAPTURE_B,
                       tpsm_pkg::MODE_CAPTURE_A};
         1: events = '{tpsm_pkg::MODE_CAPTURE_A, tpsm_pkg::MODE_CAPTURE_C,
                       tpsm_pkg::MODE_CAPTURE_B};
         default: events = '{tpsm_pkg::MODE_CAPTURE_B, tpsm_pkg::MODE_CAPTURE_A,
                             tpsm_pkg::MODE_CAPTURE_C};
      endcase
      if (broken) events[$urandom_range(0, 2)] = 2'($urandom_range(0, 3));
      for (int i = 0; i < 3; i++) send_event(events[i], stamp_for(events[i]));
   endtask

   task automatic run_traffic(input int count);
      int stop_at;
      logic [1:0] mode;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if (slot_now != tpsm_pkg::SLOT_FIRST || $urandom_range(0, 99) < 12) begin
            mode = 2'($urandom_range(0, 3));
            send_event(mode, stamp_for(mode));
         end else begin
            send_round($urandom_range(0, 2), $urandom_range(0, 99) < 10);
         end
      end
   endtask

   task automatic test_reset_round();
      choose_idling(0);
      repeat (3) send_event(tpsm_pkg::MODE_OVERFLOW, 16'h0000);
   endtask

   task automatic test_directed_rounds();
      logic [1:0] modes [21];
      logic [15:0] stamps [21];
      modes = '{tpsm_pkg::MODE_CAPTURE_A, tpsm_pkg::MODE_CAPTURE_B, tpsm_pkg::MODE_CAPTURE_C,
                tpsm_pkg::MODE_CAPTURE_C, tpsm_pkg::MODE_CAPTURE_B, tpsm_pkg::MODE_CAPTURE_A,
                tpsm_pkg::MODE_CAPTURE_A, tpsm_pkg::MODE_CAPTURE_C, tpsm_pkg::MODE_CAPTURE_B,
                tpsm_pkg::MODE_CAPTURE_B, tpsm_pkg::MODE_CAPTURE_A, tpsm_pkg::MODE_CAPTURE_C,
                tpsm_pkg::MODE_CAPTURE_B, tpsm_pkg::MODE_CAPTURE_A, tpsm_pkg::MODE_CAPTURE_C,
                tpsm_pkg::MODE_CAPTURE_A, tpsm_pkg::MODE_CAPTURE_A, tpsm_pkg::MODE_OVERFLOW,
                tpsm_pkg::MODE_CAPTURE_B, tpsm_pkg::MODE_CAPTURE_C, tpsm_pkg::MODE_OVERFLOW};
      stamps = '{16'hF000, 16'h1000, 16'h3000,
                 16'h5000, 16'h0C01, 16'hFFFF,
                 16'h1234, 16'h5400, 16'h2E34,
                 16'h5A34, 16'h0000, 16'h7A34,
                 16'h2000, 16'hABCD, 16'h5000,
                 16'h0001, 16'h8000, 16'h0000,
                 16'h4000, 16'h6000, 16'hFFFF};
      choose_idling(0);
      for (int i = 0; i < 21; i++) send_event(modes[i], stamps[i]);
   endtask

   task automatic test_default_window_traffic();
      choose_idling(0);
      run_traffic(300);
   endtask

   task automatic test_backpressure();
      choose_idling(0);
      hold_request = 1'b1;
      run_traffic(40);
   endtask

   task automatic test_window_extremes();
      set_window(16'h0000, 16'hFFFF);
      choose_idling(1);
      run_traffic(250);
      set_window(16'hFFFF, 16'h0000);
      choose_idling(2);
      run_traffic(200);
      set_window(16'h3000, 16'h3000);
      choose_idling(3);
      run_traffic(200);
   endtask

   task automatic test_random_windows();
      logic [15:0] lo;
      logic [15:0] hi;
      for (int k = 0; k < 8; k++) begin
         if (k == 5) begin
            lo = 16'($urandom_range(0, 65535));
            hi = 16'($urandom_range(0, 65535));
         end else begin
            lo = 16'($urandom_range(0, 16'h4000));
            hi = lo + 16'($urandom_range(2, 16'h6000));
         end
         set_window(lo, hi);
         choose_idling(k);
         run_traffic(125);
      end
   endtask

   always @(negedge clock) begin
      if (hold_request && !hold_started) begin
         hold_left = HOLD_CYCLES;
         hold_started = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
         note_failure($sformatf("result %0d: %s is %h, expected %h", results_seen, name, got, want));
   endtask

   always @(posedge clock) begin : check_results
      tpsm_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_reports.size() == 0) begin
            note_failure($sformatf("result %0d arrived with no event pending", results_seen));
         end else begin
            want = expected_reports.pop_front();
            check_field("report_word", rsp_report_word, want.report_word);
            check_field("loss_a", 16'(rsp_loss_a), 16'(want.loss_a));
            check_field("loss_b", 16'(rsp_loss_b), 16'(want.loss_b));
            check_field("loss_c", 16'(rsp_loss_c), 16'(want.loss_c));
            check_field("order_ok", 16'(rsp_order_ok), 16'(want.order_ok));
            check_field("evaluated", 16'(rsp_evaluated), 16'(want.evaluated));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_round();
      test_directed_rounds();
      test_default_window_traffic();
      test_backpressure();
      test_window_extremes();
      test_random_windows();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/tpsm_pkg.sv
hw/rtl/tpsm_eval.sv
hw/rtl/three_phase_sequence_monitor.sv
tb/sv/three_phase_sequence_monitor_test.sv
